>>> sv/apng_ob_pkg.sv
// ----------------------------------------------------------------------------
// apng_ob_pkg
// Shared types, constants and helpers for the APNG alpha-over pixel blender.
// ----------------------------------------------------------------------------
package apng_ob_pkg;

  localparam int ChW           = 8;   // bits per channel
  localparam int NumCh         = 4;   // channels per pixel
  localparam int NumLanes      = 3;   // colour lanes through the divider
  localparam int NumW          = 24;  // weighted-sum numerator width
  localparam int DenW          = 16;  // a1 width
  localparam int DivStages     = 4;   // divider pipeline stages
  localparam int StepsPerStage = 2;   // quotient bits resolved per stage
  localparam int CfgAddrW      = 3;
  localparam int CfgDataW      = 32;

  localparam logic [ChW-1:0]  ChMax    = 8'd255;
  // a1/255 == (a1 * InvCh) >> InvShift for every a1 below 2^16
  localparam logic [DenW-1:0] InvCh    = 16'd32897;
  localparam int              InvShift = 23;

  typedef enum logic [1:0] {
    FMT_GRAY  = 2'd0,
    FMT_GRAYA = 2'd1,
    FMT_RGB   = 2'd2,
    FMT_RGBA  = 2'd3
  } fmt_t;

  typedef enum logic [1:0] {
    MODE_COPY  = 2'd0,
    MODE_KEEP  = 2'd1,
    MODE_BLEND = 2'd2
  } mode_t;

  typedef enum logic {
    REG_FORMAT = 1'b0,
    REG_BLEND  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    fmt_t fmt;
    logic blend_over;
  } cfg_t;

  typedef struct packed {
    mode_t                     mode;
    fmt_t                      fmt;
    logic [NumCh-1:0][ChW-1:0] src;
    logic [NumCh-1:0][ChW-1:0] dst;
  } pix_t;

  typedef struct packed {
    pix_t           pix;
    logic [ChW-1:0] sa;
    logic [ChW-1:0] da;
  } s1_t;

  typedef struct packed {
    pix_t            pix;
    logic [DenW-1:0] u;
    logic [DenW-1:0] v;
  } s2_t;

  typedef struct packed {
    pix_t                         pix;
    logic [DenW-1:0]              a1;
    logic [NumLanes-1:0][NumW-1:0] num;
  } num_t;

  typedef struct packed {
    pix_t                          pix;
    logic [DenW-1:0]               a1;
    logic [ChW-1:0]                aq;
    logic [NumLanes-1:0][NumW-1:0] work;
  } div_t;

  // One restoring step: remainder in the upper bits, quotient shifts in at the bottom.
  function automatic logic [NumW-1:0] div_step(input logic [NumW-1:0] work,
                                               input logic [DenW-1:0] den);
    logic [DenW:0]   trial;
    logic [DenW:0]   diff;
    logic [DenW-1:0] rem;
    logic            qbit;
    trial = {work[NumW-1:ChW], work[ChW-1]};
    diff  = trial - {1'b0, den};
    qbit  = (trial >= {1'b0, den});
    rem   = qbit ? diff[DenW-1:0] : trial[DenW-1:0];
    return {rem, work[ChW-2:0], qbit};
  endfunction

endpackage

>>> sv/apng_over_blend_pixel.sv
// ----------------------------------------------------------------------------
// apng_over_blend_pixel
// APNG "over" compositing of one non-premultiplied 8-bit pixel per transfer.
// ----------------------------------------------------------------------------
// Takes one source/destination pixel pair per clock and returns the pixel
// composited with the APNG alpha-over rule, at a sustained rate of one pixel
// per cycle while the output side is ready. In order, the stages are rule
// decode, alpha weights, weighted sums, four divider stages that each
// resolve two quotient bits of (sc*u + dc*v)/a1, and the output register.
// Every stage holds its own valid bit and advances when the stage after it
// is empty or moving, so a stall on the output side fills bubbles first and
// never drops or repeats a pixel. Format and blend enable are set over APB
// (format at 0x0, blend enable at 0x4) and must be written only while the
// pipeline is empty; each pixel carries the format it was accepted with.
module apng_over_blend_pixel import apng_ob_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // input stream
  input  logic                in_tvalid,
  output logic                in_tready,
  // [7:0] src_c0, [15:8] src_c1, [23:16] src_c2, [31:24] src_c3,
  // [39:32] dst_c0, [47:40] dst_c1, [55:48] dst_c2, [63:56] dst_c3
  input  logic [63:0]         in_tdata,
  // result stream
  output logic                out_tvalid,
  input  logic                out_tready,
  // [7:0] out_c0, [15:8] out_c1, [23:16] out_c2, [31:24] out_c3
  output logic [31:0]         out_tdata,
  // configuration
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [CfgDataW-1:0] cfg_pwdata,
  output logic [CfgDataW-1:0] cfg_prdata,
  output logic                cfg_pready
);

  cfg_t                      cfg_q;
  logic [NumCh-1:0][ChW-1:0] src, dst;
  logic                      front_vld, front_rdy;
  num_t                      front_q;
  logic [NumCh-1:0][ChW-1:0] res;

  // Unpack the pixel pair, first field in the lowest bits
  assign src = in_tdata[NumCh*ChW-1:0];
  assign dst = in_tdata[2*NumCh*ChW-1:NumCh*ChW];

  apng_ob_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg_q)
  );

  // Decode, weights and numerators
  apng_ob_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_q),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .src       (src),
    .dst       (dst),
    .out_valid (front_vld),
    .out_ready (front_rdy),
    .out_data  (front_q)
  );

  // Divide, scale alpha, assemble and hold the result until transferred
  apng_ob_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (front_vld),
    .in_ready  (front_rdy),
    .in_data   (front_q),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (res)
  );

  assign out_tdata = res;

  // A moving output must open the whole pipeline back to the input
  a_ready_chain : assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output side is ready");

  // Blended pixels always divide by at least 255, never by zero
  a_den_floor : assert property (@(posedge clk) disable iff (!rst_n)
    (front_vld && front_q.pix.mode == MODE_BLEND) |-> (front_q.a1 >= 16'd255))
    else $error("blend divisor below 255");

endmodule

>>> sv/apng_ob_cfg.sv
// ----------------------------------------------------------------------------
// apng_ob_cfg
// APB register file: pixel format and blend enable.
// ----------------------------------------------------------------------------
module apng_ob_cfg import apng_ob_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg
);

  fmt_t     fmt_r;
  logic     blend_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= FMT_RGBA;
      blend_r <= 1'b1;
    end else if (wr_en) begin
      case (idx)
        REG_FORMAT: fmt_r   <= fmt_t'(pwdata[1:0]);
        REG_BLEND:  blend_r <= pwdata[0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FORMAT: prdata = {{(CfgDataW-2){1'b0}}, fmt_r};
      REG_BLEND:  prdata = {{(CfgDataW-1){1'b0}}, blend_r};
      default:    prdata = '0;
    endcase
  end

  assign cfg.fmt        = fmt_r;
  assign cfg.blend_over = blend_r;

endmodule

>>> sv/apng_ob_front.sv
// ----------------------------------------------------------------------------
// apng_ob_front
// Three front stages: rule decode, alpha weights, weighted channel sums.
// ----------------------------------------------------------------------------
module apng_ob_front import apng_ob_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cfg_t                      cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [NumCh-1:0][ChW-1:0] src,
  input  logic [NumCh-1:0][ChW-1:0] dst,
  output logic                      out_valid,
  input  logic                      out_ready,
  output num_t                      out_data
);

  logic  s1_vld_r, s2_vld_r, s3_vld_r;
  s1_t   s1_r, s1_nxt;
  s2_t   s2_r, s2_nxt;
  num_t  s3_r, s3_nxt;
  logic  adv1, adv2, adv3;

  assign adv3     = !s3_vld_r || out_ready;
  assign adv2     = !s2_vld_r || adv3;
  assign adv1     = !s1_vld_r || adv2;
  assign in_ready = adv1;

  // Stage 1: pick alpha channel and decide which rule applies
  always_comb begin
    logic has_alpha;
    has_alpha      = (cfg.fmt == FMT_GRAYA) || (cfg.fmt == FMT_RGBA);
    s1_nxt.pix.fmt = cfg.fmt;
    s1_nxt.pix.src = src;
    s1_nxt.pix.dst = dst;
    s1_nxt.sa      = (cfg.fmt == FMT_GRAYA) ? src[1] : src[3];
    s1_nxt.da      = (cfg.fmt == FMT_GRAYA) ? dst[1] : dst[3];
    if (!(has_alpha && cfg.blend_over)) begin
      s1_nxt.pix.mode = MODE_COPY;
    end else if (s1_nxt.sa == ChMax) begin
      s1_nxt.pix.mode = MODE_COPY;
    end else if (s1_nxt.sa == '0) begin
      s1_nxt.pix.mode = MODE_KEEP;
    end else if (s1_nxt.da == '0) begin
      s1_nxt.pix.mode = MODE_COPY;
    end else begin
      s1_nxt.pix.mode = MODE_BLEND;
    end
  end

  // Stage 2: u = sa*255, v = (255-sa)*da
  always_comb begin
    s2_nxt.pix = s1_r.pix;
    s2_nxt.u   = {s1_r.sa, {ChW{1'b0}}} - {{ChW{1'b0}}, s1_r.sa};
    s2_nxt.v   = {{ChW{1'b0}}, ChMax - s1_r.sa} * {{ChW{1'b0}}, s1_r.da};
  end

  // Stage 3: numerators sc*u + dc*v and a1 = u + v
  always_comb begin
    s3_nxt.pix = s2_r.pix;
    s3_nxt.a1  = s2_r.u + s2_r.v;
    for (int i = 0; i < NumLanes; i++) begin
      s3_nxt.num[i] = ({{(NumW-ChW){1'b0}}, s2_r.pix.src[i]} * {{(NumW-DenW){1'b0}}, s2_r.u})
                    + ({{(NumW-ChW){1'b0}}, s2_r.pix.dst[i]} * {{(NumW-DenW){1'b0}}, s2_r.v});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      if (adv1) s1_vld_r <= in_valid;
      if (adv2) s2_vld_r <= s1_vld_r;
      if (adv3) s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) s1_r <= s1_nxt;
    if (adv2 && s1_vld_r) s2_r <= s2_nxt;
    if (adv3 && s2_vld_r) s3_r <= s3_nxt;
  end

  assign out_valid = s3_vld_r;
  assign out_data  = s3_r;

endmodule

>>> sv/apng_ob_div.sv
// ----------------------------------------------------------------------------
// apng_ob_div
// Pipelined restoring divider for the colour lanes, alpha scaling, and the
// output register that assembles the composited pixel.
// ----------------------------------------------------------------------------
module apng_ob_div import apng_ob_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  num_t                      in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [NumCh-1:0][ChW-1:0] out_data
);

  div_t                      st_r   [DivStages];
  div_t                      st_in  [DivStages];
  div_t                      st_nxt [DivStages];
  logic [DivStages-1:0]      vld_r;
  logic [DivStages-1:0]      vld_in;
  logic [DivStages:0]        adv;
  logic                      out_vld_r;
  logic [NumCh-1:0][ChW-1:0] out_r, out_nxt;
  logic [2*DenW-1:0]         aprod;

  assign adv[DivStages] = !out_vld_r || out_ready;
  assign in_ready       = adv[0];

  // a1/255 by reciprocal multiply
  assign aprod = {{DenW{1'b0}}, in_data.a1} * {{DenW{1'b0}}, InvCh};

  always_comb begin
    st_in[0].pix  = in_data.pix;
    st_in[0].a1   = in_data.a1;
    st_in[0].aq   = aprod[InvShift+ChW-1:InvShift];
    st_in[0].work = in_data.num;
    vld_in[0]     = in_valid;
  end

  for (genvar k = 0; k < DivStages; k++) begin : g_stage
    if (k > 0) begin : g_link
      assign st_in[k]  = st_r[k-1];
      assign vld_in[k] = vld_r[k-1];
    end

    assign adv[k] = !vld_r[k] || adv[k+1];

    always_comb begin
      st_nxt[k] = st_in[k];
      for (int i = 0; i < NumLanes; i++) begin
        for (int j = 0; j < StepsPerStage; j++) begin
          st_nxt[k].work[i] = div_step(st_nxt[k].work[i], st_in[k].a1);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv[k]) begin
        vld_r[k] <= vld_in[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k] && vld_in[k]) st_r[k] <= st_nxt[k];
    end
  end

  // Assemble the result and drop channels the format does not use
  always_comb begin
    logic [NumCh-1:0][ChW-1:0] res;
    div_t                      last;
    last = st_r[DivStages-1];
    case (last.pix.mode)
      MODE_COPY: res = last.pix.src;
      MODE_KEEP: res = last.pix.dst;
      MODE_BLEND: begin
        res[0] = last.work[0][ChW-1:0];
        res[1] = (last.pix.fmt == FMT_GRAYA) ? last.aq : last.work[1][ChW-1:0];
        res[2] = last.work[2][ChW-1:0];
        res[3] = last.aq;
      end
      default:   res = last.pix.src;
    endcase
    for (int i = 0; i < NumCh; i++) begin
      out_nxt[i] = (i <= int'(last.pix.fmt)) ? res[i] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv[DivStages]) begin
      out_vld_r <= vld_r[DivStages-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[DivStages] && vld_r[DivStages-1]) out_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the APNG alpha-over pixel blender.
// ----------------------------------------------------------------------------
// Streams source/destination pixel pairs through the blender under every
// pixel format with blending on and off. A scoreboard class computes each
// composited pixel at input transfer time and compares it per channel with
// the result stream. Both stream sides idle at random, with bursts of
// back-to-back traffic and one long output stall that backs up the pipeline.
// Format and blend enable are set over APB only while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_top;
  import apng_ob_pkg::*;

  localparam int CycleLimit = 400000;  // abort threshold for a hung run
  localparam int PipeDrain  = 16;      // cycles to let the pipeline empty out
  localparam int LongHold   = 400;     // length of the deliberate output stall

  // Expected composited pixels, in input transfer order.
  class pixel_scoreboard;
    fmt_t        fmt;
    logic        blend;
    logic [31:0] expected_px[$];
    int          errors;
    int          checked;

    function new();
      fmt     = FMT_RGBA;
      blend   = 1'b1;
      errors  = 0;
      checked = 0;
    endfunction

    // Alpha-over composite of one pixel under the current settings.
    function logic [31:0] composite(logic [63:0] pix);
      logic [7:0]  s[4];
      logic [7:0]  d[4];
      logic [7:0]  r[4];
      logic [31:0] res;
      int unsigned n, ai, sa, da, u, v, a1;
      int          i;
      n  = int'(fmt) + 1;
      ai = (fmt == FMT_GRAYA) ? 1 : 3;
      for (i = 0; i < 4; i++) begin
        s[i] = pix[8*i +: 8];
        d[i] = pix[32 + 8*i +: 8];
        r[i] = s[i];
      end
      if ((fmt == FMT_GRAYA || fmt == FMT_RGBA) && blend) begin
        sa = s[ai];
        da = d[ai];
        if (sa == 0) begin
          // transparent source: keep the destination as is
          for (i = 0; i < 4; i++) r[i] = d[i];
        end else if (sa != ChMax && da != 0) begin
          u  = sa * ChMax;
          v  = (ChMax - sa) * da;
          a1 = u + v;
          for (i = 0; i < int'(n); i++)
            if (i != int'(ai)) r[i] = 8'((s[i] * u + d[i] * v) / a1);
          r[ai] = 8'(a1 / ChMax);
        end
      end
      for (i = 0; i < 4; i++) res[8*i +: 8] = (i < int'(n)) ? r[i] : 8'd0;
      return res;
    endfunction

    function void note_pixel(logic [63:0] pix);
      expected_px.push_back(composite(pix));
    endfunction

    function void check_pixel(logic [31:0] got);
      logic [31:0] want;
      int          i;
      if (expected_px.size() == 0) begin
        $error("unexpected result transfer, out_tdata %h", got);
        errors++;
        return;
      end
      want = expected_px.pop_front();
      checked++;
      for (i = 0; i < 4; i++)
        if (got[8*i +: 8] !== want[8*i +: 8]) begin
          $error("out_c%0d: expected %0d, got %0d", i, want[8*i +: 8], got[8*i +: 8]);
          errors++;
        end
    endfunction

    function int pending();
      return expected_px.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [63:0]         in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [31:0]         out_tdata;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CfgAddrW-1:0] cfg_paddr;
  logic [CfgDataW-1:0] cfg_pwdata;
  logic [CfgDataW-1:0] cfg_prdata;
  logic                cfg_pready;

  pixel_scoreboard sb = new();

  bit tx_nogap;          // sender offers back to back
  bit rx_nogap;          // receiver always ready
  int hold_request;      // cycles the receiver should stall next
  int cycle_count;
  int settings_count;

  apng_over_blend_pixel dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Abort a hung run.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, sb.pending());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Offer one pixel pair after an idle gap; return at the falling edge after
  // the transfer so the next call can keep tvalid high without a glitch.
  task automatic send_pixel(logic [63:0] pix, int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_pixel(pix);
    @(negedge clk);
  endtask

  // APB write followed by a read-back of the same register.
  task automatic write_reg(reg_idx_t idx, logic [CfgDataW-1:0] val);
    logic [CfgDataW-1:0] rd;
    logic [CfgDataW-1:0] mask;
    mask = (idx == REG_FORMAT) ? 32'h3 : 32'h1;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CfgAddrW'({idx, 2'b00});
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    // read back: new setup phase with psel held
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rd = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    // hold the bus idle before the next access
    @(negedge clk);
    if (rd !== (val & mask)) begin
      $error("prdata at 0x%0h: expected %0d, got %0d", {idx, 2'b00}, val & mask, rd);
      sb.errors++;
    end
  endtask

  // Let the pipeline empty out, then switch format and blend enable.
  task automatic set_config(fmt_t f, logic b);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (PipeDrain) @(negedge clk);
    write_reg(REG_FORMAT, CfgDataW'(f));
    write_reg(REG_BLEND, CfgDataW'(b));
    sb.fmt   = f;
    sb.blend = b;
    settings_count++;
  endtask

  // Alpha values biased toward the special cases of the blend rule.
  function automatic logic [7:0] pick_alpha();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd1;
      3:       return 8'd254;
      default: return 8'($urandom);
    endcase
  endfunction

  // Receiver: stall at random between results, take the long hold when asked.
  initial begin
    int gap;
    out_tready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (hold_request > 0) begin
        gap          = hold_request;
        hold_request = 0;
      end else begin
        gap = rx_nogap ? 0 : $urandom_range(0, 15);
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      sb.check_pixel(out_tdata);
      @(negedge clk);
    end
  end

  // Stimulus: directed corners, then random pixels under a sweep of settings.
  initial begin
    logic [63:0] directed[$];
    logic [63:0] pix;
    int          p, k, count, mode;
    fmt_t        f;
    logic        b;

    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    tx_nogap       = 1'b0;
    rx_nogap       = 1'b0;
    hold_request   = 0;
    settings_count = 1;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: RGBA with blending. Byte order d3..d0 s3..s0.
    directed = '{
      64'h00000000_00000000,   // all zero: transparent source
      64'hFFFFFFFF_FFFFFFFF,   // all ones: opaque source
      64'h40AABBCC_FF563412,   // opaque source copied
      64'hC0204080_00ABCDEF,   // transparent source keeps destination
      64'h00112233_80C0D0E0,   // transparent destination copies source
      64'h80102030_80F0E0D0,   // plain blend
      64'hFF000000_01FFFFFF,   // faintest source over opaque destination
      64'h01FFFFFF_FE000000,   // near-opaque source over faint destination
      64'h01FF00FF_0100FF00    // both faint
    };
    foreach (directed[k]) send_pixel(directed[k], k % 3);

    // Gray+alpha: alpha sits in channel 1, channels 2 and 3 ignored.
    set_config(FMT_GRAYA, 1'b1);
    directed = '{
      64'h5566FF00_AABBFF10,   // opaque source
      64'h5566C040_AABB0010,   // transparent source keeps gray and alpha
      64'h55660040_AABB7710,   // transparent destination
      64'hFFFF80F0_00008020,   // plain blend
      64'h0000FF00_0000FF01 ^ 64'h0000FF00_0000FE00  // source alpha 1
    };
    foreach (directed[k]) send_pixel(directed[k], 0);

    // Formats without alpha copy the source whatever the alpha bytes hold.
    set_config(FMT_GRAY, 1'b1);
    send_pixel(64'h00000080_00000033, 0);
    send_pixel(64'hFFFFFFFF_000000FF, 2);
    set_config(FMT_RGB, 1'b1);
    send_pixel(64'h80402010_00A5B6C7, 0);
    send_pixel(64'hFFFFFFFF_80000000, 1);

    // Blending off: plain copy even with partial alpha.
    set_config(FMT_RGBA, 1'b0);
    send_pixel(64'h80102030_80F0E0D0, 0);
    send_pixel(64'hC0204080_00ABCDEF, 0);
    send_pixel(64'hFF000000_01FFFFFF, 0);
    set_config(FMT_GRAYA, 1'b0);
    send_pixel(64'hFFFF80F0_00008020, 0);

    // Random phases: every format with blending on and off, then two more.
    for (p = 0; p < 10; p++) begin
      if (p < 8) begin
        f = fmt_t'(2'(p % 4));
        b = (p < 4);
        count = 120;
      end else begin
        f = fmt_t'(2'($urandom_range(0, 3)));
        b = 1'($urandom_range(0, 1));
        count = 45;
      end
      set_config(f, b);
      mode     = (p / 2) % 4;
      tx_nogap = (mode == 1 || mode == 3);
      rx_nogap = (mode >= 2);
      // one long output stall while the sender keeps pushing back to back
      if (p == 2) hold_request = LongHold;
      for (k = 0; k < count; k++) begin
        pix        = {$urandom, $urandom};
        pix[15:8]  = pick_alpha();
        pix[31:24] = pick_alpha();
        pix[47:40] = pick_alpha();
        pix[63:56] = pick_alpha();
        send_pixel(pix, tx_nogap ? 0 : $urandom_range(0, 15));
      end
    end

    // Drain and give stray results time to show up.
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (PipeDrain) @(negedge clk);

    $display("Checked %0d composited pixels under %0d format/blend settings,", sb.checked,
             settings_count);
    $display("including alpha corner cases, random stalls and a long output back-pressure.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
